[rtl/core/spq_pkg.sv]
package spq_pkg;

  // Operation carried in the input tuser bit
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } spq_op_e;

  // Result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int unsigned TagW = 32;
  localparam int unsigned PriW = 16;
  localparam int unsigned OccW = 4;

  typedef enum logic {
    CTRL_IDLE = 1'b0,
    CTRL_HOLD = 1'b1
  } spq_ctrl_state_e;

  typedef struct packed {
    logic exec;
  } spq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } spq_stat_t;

endpackage

[rtl/core/spq_ctrl.sv]
module spq_ctrl
  import spq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_tvalid_i,
  output logic     s_tready_o,
  output logic     m_tvalid_o,
  input  logic     m_tready_i,
  output spq_cmd_t cmd_o
);

  spq_ctrl_state_e state_q, state_d;
  logic            accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    s_tready_o = 1'b0;
    m_tvalid_o = 1'b0;
    case (state_q)
      CTRL_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          state_d = CTRL_HOLD;
        end
      end
      CTRL_HOLD: begin
        m_tvalid_o = 1'b1;
        // take a new beat in the cycle the held result drains
        s_tready_o = m_tready_i;
        if (m_tready_i && !s_tvalid_i) begin
          state_d = CTRL_IDLE;
        end
      end
      default: begin
        state_d = CTRL_IDLE;
      end
    endcase
    accept     = s_tvalid_i && s_tready_o;
    cmd_o.exec = accept;
  end

endmodule

[rtl/core/spq_datapath.sv]
module spq_datapath
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 8,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  spq_cmd_t        cmd_i,
  input  logic            opcode_i,
  input  logic [TagW-1:0] job_tag_i,
  input  logic [PriW-1:0] priority_req_i,
  output logic [TagW-1:0] out_job_tag_o,
  output logic [PriW-1:0] out_priority_o,
  output logic [1:0]      status_o,
  output logic [OccW-1:0] occupancy_o,
  output spq_stat_t       stat_o
);

  logic [TagW-1:0] job_q [DEPTH];
  logic [PriW-1:0] pri_q [DEPTH];
  logic [TagW-1:0] job_d [DEPTH];
  logic [PriW-1:0] pri_d [DEPTH];
  logic [CntW-1:0] count_q, count_d;
  logic [DEPTH-1:0] gt;
  logic            is_full, is_empty;
  logic [TagW-1:0] res_tag_d, res_tag_q;
  logic [PriW-1:0] res_pri_d, res_pri_q;
  logic [1:0]      res_st_d, res_st_q;
  logic [CntW+OccW-1:0] occ_ext;

  assign is_full  = (count_q == CntW'(DEPTH));
  assign is_empty = (count_q == '0);

  // held entries whose priority is strictly above the new one (thermometer)
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      gt[k] = (CntW'(k) < count_q) && (pri_q[k] > priority_req_i);
    end
  end

  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      job_d[k] = job_q[k];
      pri_d[k] = pri_q[k];
    end
    count_d   = count_q;
    res_tag_d = '0;
    res_pri_d = '0;
    res_st_d  = ST_DONE;
    if (opcode_i == OP_INSERT) begin
      if (is_full) begin
        res_st_d = ST_FULL;
      end else begin
        for (int k = 0; k < DEPTH; k++) begin
          if (k > 0 && gt[(k > 0) ? k - 1 : 0]) begin
            // move down behind the new entry
            job_d[k] = job_q[(k > 0) ? k - 1 : 0];
            pri_d[k] = pri_q[(k > 0) ? k - 1 : 0];
          end else if ((gt[k] || CntW'(k) == count_q) && CntW'(k) <= count_q) begin
            job_d[k] = job_tag_i;
            pri_d[k] = priority_req_i;
          end
        end
        count_d = count_q + 1'b1;
      end
    end else begin
      if (is_empty) begin
        res_st_d = ST_EMPTY;
      end else begin
        res_tag_d = job_q[0];
        res_pri_d = pri_q[0];
        for (int k = 0; k < DEPTH - 1; k++) begin
          job_d[k] = job_q[k + 1];
          pri_d[k] = pri_q[k + 1];
        end
        count_d = count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      for (int k = 0; k < DEPTH; k++) begin
        job_q[k] <= job_d[k];
        pri_q[k] <= pri_d[k];
      end
      res_tag_q <= res_tag_d;
      res_pri_q <= res_pri_d;
      res_st_q  <= res_st_d;
    end
  end

  assign occ_ext        = {{OccW{1'b0}}, count_q};
  assign out_job_tag_o  = res_tag_q;
  assign out_priority_o = res_pri_q;
  assign status_o       = res_st_q;
  assign occupancy_o    = occ_ext[OccW-1:0];
  assign stat_o.full    = is_full;
  assign stat_o.empty   = is_empty;

endmodule

[rtl/core/sorted_priority_queue_unit.sv]
// Sorted priority queue of jobs, lowest priority number served first.
// Slave stream: one beat is one operation. s_tuser_i selects insert (0) or
// remove (1); s_tdata_i carries the job tag and priority used by an insert.
// Master stream: exactly one result beat per operation, in order, with the
// removed job (zeros on an insert or a failed remove), a status code
// (done, full so the insert was dropped, empty on remove) and the number of
// jobs held after the operation.
// Equal priorities leave in arrival order.
// The result is registered and appears on m_tvalid_o in the cycle after the input beat.
// Throughput: one item per cycle while m_tready_i stays high; the next beat is taken in the same cycle
// the held result is taken. Every entry register has its own priority
// comparator, so an insert or remove finishes in one parallel compare-and-
// shift over DEPTH entries.
// When the receiver stalls, the result stays in the output register and
// s_tready_o follows m_tready_i, so no beat is lost or overwritten.
// Reset empties the queue and clears any pending result; entry contents are
// left as they were and only held entries are ever read.
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  // [31:0] job_tag, [47:32] priority_req
  input  logic [47:0] s_tdata_i,
  // [0] opcode
  input  logic        s_tuser_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // [31:0] out_job_tag, [47:32] out_priority, [49:48] status,
  // [53:50] occupancy, [55:54] zero
  output logic [55:0] m_tdata_o
);

  spq_cmd_t        cmd;
  spq_stat_t       stat;
  logic [TagW-1:0] out_tag;
  logic [PriW-1:0] out_pri;
  logic [1:0]      out_st;
  logic [OccW-1:0] out_occ;

  // Sequence accept and result hold
  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .cmd_o      (cmd)
  );

  // Entry registers, compare-and-shift, result register
  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .opcode_i       (s_tuser_i),
    .job_tag_i      (s_tdata_i[31:0]),
    .priority_req_i (s_tdata_i[47:32]),
    .out_job_tag_o  (out_tag),
    .out_priority_o (out_pri),
    .status_o       (out_st),
    .occupancy_o    (out_occ),
    .stat_o         (stat)
  );

  assign m_tdata_o = {2'b00, out_occ, out_st, out_pri, out_tag};

`ifndef ASSERT_OFF
  // Never take a beat while an untaken result would be overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_tvalid_i && s_tready_o && m_tvalid_o && !m_tready_i))
    else $error("input beat accepted over a stalled result");

  // Full and empty never hold together
  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat.full && stat.empty))
    else $error("queue flagged both full and empty");

  // An insert into a full queue reports full on the next beat
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.exec && stat.full && (s_tuser_i == OP_INSERT))
    |=> (m_tvalid_o && (m_tdata_o[49:48] == ST_FULL)))
    else $error("insert into full queue not reported");

  // A remove from an empty queue reports empty with zero payload
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.exec && stat.empty && (s_tuser_i == OP_REMOVE))
    |=> (m_tvalid_o && (m_tdata_o[49:48] == ST_EMPTY) && (m_tdata_o[47:0] == '0)))
    else $error("remove from empty queue not reported");
`endif

endmodule
